### rtl/core/dtpc_pkg.sv
// shared types and constants for the digit trie prefix-free checker
// no dependencies; imported by dtpc_store, digit_trie_prefix_check and dtpc_checker
package dtpc_pkg;

    // default pool size in trie nodes
    localparam int POOL_NODES_DEFAULT = 1024;

    // decimal digits and child slots per node
    localparam int         DIGIT_W   = 4;
    localparam int         DIGITS    = 10;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // verdict codes
    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_CONFLICT  = 2'd1;
    localparam logic [1:0] VERDICT_POOL_FULL = 2'd2;

    // node marks
    typedef enum logic [1:0] {
        MARK_FREE = 2'd0,
        MARK_PASS = 2'd1,
        MARK_END  = 2'd2
    } mark_t;

    // one node entry: mark plus a presence bit per child digit
    typedef struct packed {
        mark_t             mark;
        logic [DIGITS-1:0] present;
    } node_t;

    // input item
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
        logic               new_list;
    } in_t;

    // result item
    typedef struct packed {
        logic [1:0] verdict;
        logic       list_ok;
    } out_t;

    // walk sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_NODE  = 2'd1,
        S_CHILD = 2'd2,
        S_EMIT  = 2'd3
    } state_t;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic node_we;
        logic node_re;
        logic link_we;
        logic link_re;
    } store_ctl_t;

endpackage

### rtl/core/dtpc_store.sv
// node pool storage: node mark/presence memory and child link memory
// depends on dtpc_pkg; one write and one registered read port per memory
module dtpc_store #(
    parameter int POOL_NODES = dtpc_pkg::POOL_NODES_DEFAULT
) (
    input  logic                                              clk,
    input  dtpc_pkg::store_ctl_t                              ctl,
    input  logic [$clog2(POOL_NODES)-1:0]                     node_waddr,
    input  dtpc_pkg::node_t                                   node_wdata,
    input  logic [$clog2(POOL_NODES)-1:0]                     node_raddr,
    output dtpc_pkg::node_t                                   node_rdata,
    input  logic [$clog2(dtpc_pkg::DIGITS*POOL_NODES)-1:0]    link_waddr,
    input  logic [$clog2(POOL_NODES)-1:0]                     link_wdata,
    input  logic [$clog2(dtpc_pkg::DIGITS*POOL_NODES)-1:0]    link_raddr,
    output logic [$clog2(POOL_NODES)-1:0]                     link_rdata
);
    import dtpc_pkg::*;

    localparam int NW        = $clog2(POOL_NODES);
    localparam int LINK_DEPTH = DIGITS * POOL_NODES;

    node_t            node_mem [POOL_NODES];
    logic [NW-1:0]    link_mem [LINK_DEPTH];
    node_t            node_rdata_reg;
    logic [NW-1:0]    link_rdata_reg;

    // node memory, write data forwarded on a same-address read
    always_ff @(posedge clk)
    begin
        if (ctl.node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (ctl.node_re)
        begin
            if (ctl.node_we && (node_waddr == node_raddr))
            begin
                node_rdata_reg <= node_wdata;
            end
            else
            begin
                node_rdata_reg <= node_mem[node_raddr];
            end
        end
    end

    // child link memory
    always_ff @(posedge clk)
    begin
        if (ctl.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctl.link_re)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    assign node_rdata = node_rdata_reg;
    assign link_rdata = link_rdata_reg;

endmodule

### rtl/core/digit_trie_prefix_check.sv
// prefix-free check of decimal number lists over a trie in a node pool
// one digit per transfer; a walked digit passes the node state, then the child
// state when a child node is allocated or checked, and a last digit the emit
// state to load the result register; an ignored digit stays in the idle state
// the states follow the dependent registered reads of the node memory
// rst_n clears the walk state and empties the trie; memories are not cleared
module digit_trie_prefix_check #(
    parameter int POOL_NODES = dtpc_pkg::POOL_NODES_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           digit_valid,
    output logic           digit_ready,
    input  dtpc_pkg::in_t  digit_item,
    output logic           result_valid,
    input  logic           result_ready,
    output dtpc_pkg::out_t result
);
    import dtpc_pkg::*;

    localparam int NW  = $clog2(POOL_NODES);
    localparam int FCW = $clog2(POOL_NODES + 1);
    localparam int LAW = $clog2(DIGITS * POOL_NODES);

    // link slot of a node's child digit: node * 10 + digit
    function automatic logic [LAW-1:0] link_index(input logic [NW-1:0] node,
                                                   input logic [3:0]    d);
        return LAW'({node, 3'b000}) + LAW'({node, 1'b0}) + LAW'(d);
    endfunction

    state_t          state_reg, state_next;
    logic [FCW-1:0]  free_count_reg, free_count_next;
    logic [NW-1:0]   cur_node_reg, cur_node_next;
    logic            number_failed_reg, number_failed_next;
    logic            list_failed_reg, list_failed_next;
    logic            fail_pool_reg, fail_pool_next;
    logic            result_valid_reg, result_valid_next;
    logic [3:0]      digit_reg, digit_next;
    logic            last_reg, last_next;
    logic            root_new_reg, root_new_next;
    logic            child_new_reg, child_new_next;
    out_t            result_reg, result_next;

    // memory ports
    store_ctl_t      ctl;
    logic [NW-1:0]   node_waddr, node_raddr;
    node_t           node_wdata, node_rdata;
    logic [LAW-1:0]  link_waddr, link_raddr;
    logic [NW-1:0]   link_wdata, link_rdata;

    // transfer-time view with a new list applied
    logic            accept;
    logic            fresh;
    logic [FCW-1:0]  fc_eff, fc_walk;
    logic [NW-1:0]   cur_eff, cur_sel;
    logic            nf_eff, lf_eff, fp_eff;
    logic [3:0]      d_clamp;
    logic            ignore_digit, skip_digit, root_new;

    // node stage view
    node_t           node_cur;
    logic            is_end, has_child, pool_full;
    logic [NW-1:0]   child_sel, new_node;
    logic [DIGITS-1:0] digit_bit;

    // child stage view
    logic            child_used;
    logic            out_free;

    assign accept   = digit_valid && (state_reg == S_IDLE);
    assign fresh    = digit_item.new_list;
    assign fc_eff   = fresh ? '0 : free_count_reg;
    assign cur_eff  = fresh ? '0 : cur_node_reg;
    assign nf_eff   = !fresh && number_failed_reg;
    assign lf_eff   = !fresh && list_failed_reg;
    assign fp_eff   = !fresh && fail_pool_reg;
    assign d_clamp  = (digit_item.digit > DIGIT_MAX) ? DIGIT_MAX : digit_item.digit;
    assign ignore_digit = lf_eff && !nf_eff;
    assign skip_digit   = nf_eff;
    assign root_new = (fc_eff == '0);
    assign fc_walk  = root_new ? FCW'(1) : fc_eff;
    assign cur_sel  = (FCW'(cur_eff) >= fc_walk) ? '0 : cur_eff;

    assign node_cur  = root_new_reg ? node_t'('0) : node_rdata;
    assign is_end    = (node_cur.mark == MARK_END);
    assign has_child = node_cur.present[digit_reg];
    assign pool_full = (free_count_reg >= FCW'(POOL_NODES));
    assign child_sel = (FCW'(link_rdata) < free_count_reg) ? link_rdata : '0;
    assign new_node  = free_count_reg[NW-1:0];
    assign digit_bit = DIGITS'(1) << digit_reg;

    assign child_used = (node_rdata.mark != MARK_FREE);
    assign out_free   = !result_valid_reg || result_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !ignore_digit)
                begin
                    if (skip_digit)
                    begin
                        state_next = digit_item.last_digit ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_NODE;
                    end
                end
            end
            S_NODE:
            begin
                if (is_end || (!has_child && pool_full))
                begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
                else if (has_child)
                begin
                    state_next = last_reg ? S_CHILD : S_IDLE;
                end
                else
                begin
                    state_next = S_CHILD;
                end
            end
            S_CHILD:
            begin
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory requests and result
    always_comb
    begin
        free_count_next    = free_count_reg;
        cur_node_next      = cur_node_reg;
        number_failed_next = number_failed_reg;
        list_failed_next   = list_failed_reg;
        fail_pool_next     = fail_pool_reg;
        digit_next         = digit_reg;
        last_next          = last_reg;
        root_new_next      = root_new_reg;
        child_new_next     = child_new_reg;
        result_valid_next  = result_valid_reg && !result_ready;
        result_next        = result_reg;
        ctl                = '0;
        node_waddr         = cur_node_reg;
        node_wdata         = '0;
        node_raddr         = cur_sel;
        link_waddr         = link_index(cur_node_reg, digit_reg);
        link_wdata         = new_node;
        link_raddr         = link_index(cur_sel, d_clamp);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    free_count_next    = fc_eff;
                    cur_node_next      = cur_eff;
                    number_failed_next = nf_eff;
                    list_failed_next   = lf_eff;
                    fail_pool_next     = fp_eff;
                    digit_next         = d_clamp;
                    last_next          = digit_item.last_digit;
                    if (!ignore_digit && !skip_digit)
                    begin
                        // root taken on the first digit of an empty trie
                        root_new_next   = root_new;
                        free_count_next = fc_walk;
                        cur_node_next   = cur_sel;
                        ctl.node_re     = 1'b1;
                        ctl.link_re     = 1'b1;
                    end
                end
            end
            S_NODE:
            begin
                if (is_end)
                begin
                    // walk passes a number end
                    number_failed_next = 1'b1;
                    list_failed_next   = 1'b1;
                    fail_pool_next     = 1'b0;
                end
                else
                begin
                    ctl.node_we     = 1'b1;
                    node_wdata.mark = MARK_PASS;
                    node_wdata.present = node_cur.present;
                    if (has_child)
                    begin
                        cur_node_next  = child_sel;
                        child_new_next = 1'b0;
                        node_raddr     = child_sel;
                        ctl.node_re    = last_reg;
                    end
                    else if (pool_full)
                    begin
                        number_failed_next = 1'b1;
                        list_failed_next   = 1'b1;
                        fail_pool_next     = 1'b1;
                    end
                    else
                    begin
                        // take the next pool node as this digit's child
                        node_wdata.present = node_cur.present | digit_bit;
                        ctl.link_we        = 1'b1;
                        free_count_next    = free_count_reg + FCW'(1);
                        cur_node_next      = new_node;
                        child_new_next     = 1'b1;
                    end
                end
            end
            S_CHILD:
            begin
                if (child_new_reg)
                begin
                    // clear the fresh node, ending the number there on a last digit
                    ctl.node_we     = 1'b1;
                    node_wdata.mark = last_reg ? MARK_END : MARK_FREE;
                end
                else if (child_used)
                begin
                    number_failed_next = 1'b1;
                    list_failed_next   = 1'b1;
                    fail_pool_next     = 1'b0;
                end
                else
                begin
                    ctl.node_we        = 1'b1;
                    node_wdata.mark    = MARK_END;
                    node_wdata.present = node_rdata.present;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    if (!number_failed_reg)
                    begin
                        result_next.verdict = VERDICT_OK;
                    end
                    else if (fail_pool_reg)
                    begin
                        result_next.verdict = VERDICT_POOL_FULL;
                    end
                    else
                    begin
                        result_next.verdict = VERDICT_CONFLICT;
                    end
                    result_next.list_ok = !list_failed_reg;
                    cur_node_next       = '0;
                    number_failed_next  = 1'b0;
                    fail_pool_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_count_reg    <= '0;
            cur_node_reg      <= '0;
            number_failed_reg <= 1'b0;
            list_failed_reg   <= 1'b0;
            fail_pool_reg     <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            free_count_reg    <= free_count_next;
            cur_node_reg      <= cur_node_next;
            number_failed_reg <= number_failed_next;
            list_failed_reg   <= list_failed_next;
            fail_pool_reg     <= fail_pool_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // per-digit payload
    always_ff @(posedge clk)
    begin
        digit_reg     <= digit_next;
        last_reg      <= last_next;
        root_new_reg  <= root_new_next;
        child_new_reg <= child_new_next;
        result_reg    <= result_next;
    end

    // node pool memories
    dtpc_store #(
        .POOL_NODES (POOL_NODES)
    ) u_store (
        .clk        (clk),
        .ctl        (ctl),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata)
    );

    assign digit_ready  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/core/dtpc_checker.sv
// port-level assertions for digit_trie_prefix_check, bound to the top level
// depends on dtpc_pkg and digit_trie_prefix_check
module dtpc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           digit_valid,
    input logic           digit_ready,
    input dtpc_pkg::in_t  digit_item,
    input logic           result_valid,
    input logic           result_ready,
    input dtpc_pkg::out_t result
);
    import dtpc_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // only defined verdict codes
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.verdict == VERDICT_OK) ||
                         (result.verdict == VERDICT_CONFLICT) ||
                         (result.verdict == VERDICT_POOL_FULL))
        else $error("undefined verdict code");

    // an accepted number keeps the list ok, a failed one clears it
    a_verdict_list: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.verdict == VERDICT_OK) == result.list_ok))
        else $error("list_ok disagrees with verdict");

    // a result is loaded only while digit transfers are held off
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(digit_ready))
        else $error("result loaded while taking digits");

endmodule

bind digit_trie_prefix_check dtpc_checker u_dtpc_checker (.*);
